// ===== sv/nca_pkg.sv =====
// Package for the nearest-centroid assignment block.
// Holds the sizes, field widths, codes and the structs passed between the top level and its cells.
// Depends on nothing.
package nca_pkg;

   localparam int SLOT_COUNT = 64;
   localparam int MAX_LENGTH = 256;

   localparam int SLOT_W  = $clog2(SLOT_COUNT);
   localparam int INDEX_W = $clog2(MAX_LENGTH);
   localparam int COUNT_W = 7;
   localparam int LEN_W   = 9;
   localparam int VALUE_W = 16;
   localparam int SQ_W    = 2 * VALUE_W;
   localparam int SUM_W   = 48;

   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = LEN_W;

   localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(1);
   localparam logic [LEN_W-1:0]   LEN_RESET   = LEN_W'(16);

   typedef enum logic {
      KIND_LOAD  = 1'b0,
      KIND_QUERY = 1'b1
   } kind_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_CENTROID_COUNT = 1'b0,
      CSR_VECTOR_LENGTH  = 1'b1
   } csr_index_type;

   // One pipeline stage of the broadcast bus that runs past every cell.
   typedef struct packed {
      logic                load;
      logic                acc;
      logic                clear;
      logic                last;
      logic [SLOT_W-1:0]   slot;
      logic [INDEX_W-1:0]  index;
      logic [VALUE_W-1:0]  value;
   } stage_type;

   // Running minimum handed from cell to cell during the search.
   typedef struct packed {
      logic                valid;
      logic [SUM_W-1:0]    sum;
      logic [SLOT_W-1:0]   idx;
   } tok_type;

endpackage

// ===== sv/nca_if.sv =====
// Channel interfaces of the nearest-centroid assignment block.
// Request, response and register-write channels, each with valid, ready and payload.
// Depends on nca_pkg.
interface nca_req_if import nca_pkg::*; ();
   logic                valid;
   logic                ready;
   logic                kind;
   logic [SLOT_W-1:0]   centroid_slot;
   logic [INDEX_W-1:0]  component_index;
   logic signed [VALUE_W-1:0] component_value;

   modport source (output valid, kind, centroid_slot, component_index, component_value,
                   input ready);
   modport sink (input valid, kind, centroid_slot, component_index, component_value,
                 output ready);
endinterface

interface nca_rsp_if import nca_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [SLOT_W-1:0]   best_centroid;

   modport source (output valid, best_centroid, input ready);
   modport sink (input valid, best_centroid, output ready);
endinterface

interface nca_csr_if import nca_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CSR_DATA_W-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ===== sv/nca_cell.sv =====
// One centroid cell: component memory, squarer, saturating distance accumulator
// and one step of the minimum search chain.
// Depends on nca_pkg.
module nca_cell import nca_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic [SLOT_W-1:0] cell_id,
   input  logic              in_use,
   input  stage_type         stage_a,
   input  stage_type         stage_b,
   input  stage_type         stage_c,
   input  tok_type           prev_tok,
   output tok_type           next_tok
);

   logic [VALUE_W-1:0]          mem [MAX_LENGTH];
   logic [VALUE_W-1:0]          rd_ff;
   logic signed [VALUE_W:0]     diff;
   logic signed [2*VALUE_W+1:0] prod;
   logic [SQ_W-1:0]             sq_ff;
   logic [SQ_W-1:0]             sq_in;
   logic [SUM_W-1:0]            sum_ff;
   logic [SUM_W-1:0]            sum_in;
   logic [SUM_W-1:0]            base;
   logic [SUM_W:0]              total;
   tok_type                     tok_ff;
   tok_type                     tok_in;

   always_ff @(posedge clock) begin
      if (stage_a.load && stage_a.slot == cell_id) begin
         mem[stage_a.index] <= stage_a.value;
      end
      rd_ff <= mem[stage_a.index];
   end

   always_comb begin
      diff  = $signed({stage_b.value[VALUE_W-1], stage_b.value})
            - $signed({rd_ff[VALUE_W-1], rd_ff});
      prod  = diff * diff;
      sq_in = prod[SQ_W-1:0];
   end

   always_ff @(posedge clock) begin
      sq_ff <= sq_in;
   end

   always_comb begin
      base  = stage_c.clear ? '0 : sum_ff;
      total = {1'b0, base} + {{(SUM_W + 1 - SQ_W){1'b0}}, sq_ff};
      if (stage_c.acc) begin
         if (in_use) begin
            sum_in = total[SUM_W] ? '1 : total[SUM_W-1:0];
         end else begin
            sum_in = base;
         end
      end else begin
         sum_in = sum_ff;
      end
   end

   // The first cell always takes the token; later cells take it only on a strictly smaller sum.
   always_comb begin
      tok_in = prev_tok;
      if (prev_tok.valid && in_use && (cell_id == '0 || sum_ff < prev_tok.sum)) begin
         tok_in.sum = sum_ff;
         tok_in.idx = cell_id;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff       <= '0;
         tok_ff.valid <= 1'b0;
      end else begin
         sum_ff       <= sum_in;
         tok_ff.valid <= tok_in.valid;
      end
      tok_ff.sum <= tok_in.sum;
      tok_ff.idx <= tok_in.idx;
   end

   assign next_tok = tok_ff;

endmodule

// ===== sv/nearest_centroid_assign.sv =====
// Top level of the nearest-centroid assignment block: channels, registers,
// broadcast pipeline, the row of centroid cells and the result register.
// Depends on nca_pkg, nca_if and nca_cell.
//
//   channel   direction   carries
//   req_ch    in          kind, centroid_slot, component_index, component_value
//   rsp_ch    out         best_centroid
//   csr_ch    in          index, data (centroid_count, vector_length)
//
// A load or a query component that is not the last one leaves the request channel
// open, so such transactions may arrive back to back. After the last component of
// a query the request channel stays closed while the running minimum walks once
// through the row of cells, one cell per cycle. A waiting result does not block new
// requests, but the next search only finishes after it is taken. Reset is synchronous;
// the centroid memories are not cleared.
module nearest_centroid_assign import nca_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   nca_req_if.sink     req_ch,
   nca_rsp_if.source   rsp_ch,
   nca_csr_if.sink     csr_ch
);

   logic [COUNT_W-1:0]    count_ff;
   logic [COUNT_W-1:0]    count_in;
   logic [LEN_W-1:0]      len_ff;
   logic [LEN_W-1:0]      len_in;
   logic [COUNT_W-1:0]    count_eff;
   logic [LEN_W-1:0]      len_eff;
   logic [SLOT_COUNT-1:0] in_use;

   logic      req_accept;
   logic      in_range;
   logic      is_last;
   stage_type a_ff;
   stage_type a_in;
   stage_type b_ff;
   stage_type c_ff;
   logic      start_ff;
   logic      busy_ff;
   logic      busy_in;
   logic      pend_vld_ff;
   logic      pend_vld_in;
   logic [SLOT_W-1:0] pend_idx_ff;
   logic      rsp_vld_ff;
   logic      rsp_vld_in;
   logic [SLOT_W-1:0] rsp_idx_ff;
   logic      pend_move;

   tok_type   tok [SLOT_COUNT + 1];

   // Register writes.
   assign csr_ch.ready = 1'b1;

   always_comb begin
      count_in = count_ff;
      len_in   = len_ff;
      if (csr_ch.valid) begin
         unique case (csr_index_type'(csr_ch.index))
            CSR_CENTROID_COUNT: count_in = csr_ch.data[COUNT_W-1:0];
            CSR_VECTOR_LENGTH:  len_in   = csr_ch.data[LEN_W-1:0];
            default:            count_in = count_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= COUNT_RESET;
         len_ff   <= LEN_RESET;
      end else begin
         count_ff <= count_in;
         len_ff   <= len_in;
      end
   end

   always_comb begin
      if (count_ff == '0) begin
         count_eff = COUNT_W'(1);
      end else if (count_ff > COUNT_W'(SLOT_COUNT)) begin
         count_eff = COUNT_W'(SLOT_COUNT);
      end else begin
         count_eff = count_ff;
      end
      if (len_ff == '0) begin
         len_eff = LEN_W'(1);
      end else if (len_ff > LEN_W'(MAX_LENGTH)) begin
         len_eff = LEN_W'(MAX_LENGTH);
      end else begin
         len_eff = len_ff;
      end
   end

   // Request intake and the broadcast pipeline.
   assign req_ch.ready = !busy_ff;
   assign req_accept   = req_ch.valid && !busy_ff;

   always_comb begin
      in_range   = {{(LEN_W - INDEX_W){1'b0}}, req_ch.component_index} < len_eff;
      is_last    = {{(LEN_W - INDEX_W){1'b0}}, req_ch.component_index} == len_eff - LEN_W'(1);
      a_in.load  = req_accept && req_ch.kind == KIND_LOAD;
      a_in.acc   = req_accept && req_ch.kind == KIND_QUERY && in_range;
      a_in.clear = req_ch.component_index == '0;
      a_in.last  = is_last;
      a_in.slot  = req_ch.centroid_slot;
      a_in.index = req_ch.component_index;
      a_in.value = req_ch.component_value;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_ff     <= '0;
         b_ff     <= '0;
         c_ff     <= '0;
         start_ff <= 1'b0;
      end else begin
         a_ff     <= a_in;
         b_ff     <= a_ff;
         c_ff     <= b_ff;
         start_ff <= c_ff.acc && c_ff.last;
      end
   end

   // Row of centroid cells.
   assign tok[0] = '{valid: start_ff, sum: '0, idx: '0};

   for (genvar j = 0; j < SLOT_COUNT; j++) begin : g_cell
      assign in_use[j] = COUNT_W'(j) < count_eff;

      nca_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .cell_id  (SLOT_W'(j)),
         .in_use   (in_use[j]),
         .stage_a  (a_ff),
         .stage_b  (b_ff),
         .stage_c  (c_ff),
         .prev_tok (tok[j]),
         .next_tok (tok[j+1])
      );
   end

   // Result hand-off.
   assign pend_move = pend_vld_ff && (!rsp_vld_ff || rsp_ch.ready);

   always_comb begin
      busy_in     = busy_ff;
      pend_vld_in = pend_vld_ff;
      rsp_vld_in  = rsp_vld_ff;
      if (rsp_vld_ff && rsp_ch.ready) begin
         rsp_vld_in = 1'b0;
      end
      if (tok[SLOT_COUNT].valid) begin
         pend_vld_in = 1'b1;
      end
      if (pend_move) begin
         pend_vld_in = 1'b0;
         rsp_vld_in  = 1'b1;
         busy_in     = 1'b0;
      end
      if (a_in.acc && a_in.last) begin
         busy_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff     <= 1'b0;
         pend_vld_ff <= 1'b0;
         rsp_vld_ff  <= 1'b0;
      end else begin
         busy_ff     <= busy_in;
         pend_vld_ff <= pend_vld_in;
         rsp_vld_ff  <= rsp_vld_in;
      end
      if (tok[SLOT_COUNT].valid) begin
         pend_idx_ff <= tok[SLOT_COUNT].idx;
      end
      if (pend_move) begin
         rsp_idx_ff <= pend_idx_ff;
      end
   end

   assign rsp_ch.valid         = rsp_vld_ff;
   assign rsp_ch.best_centroid = rsp_idx_ff;

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for nearest_centroid_assign: directed and random request streams,
// a cycle-free predictor of the nearest-centroid search and an in-order result checker.
// Depends on nca_pkg, the nca_*_if interfaces and the nearest_centroid_assign RTL.
module testbench import nca_pkg::*; ();

   localparam int RANDOM_ITEMS   = 1100;
   localparam int SETTLE_CYCLES  = SLOT_COUNT + 16;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int PRINT_LIMIT    = 50;

   logic clock;
   logic reset;

   nca_req_if req_ch ();
   nca_rsp_if rsp_ch ();
   nca_csr_if csr_ch ();

   nearest_centroid_assign u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   // Predicted state of the block.
   logic [VALUE_W-1:0] centroid_mem [SLOT_COUNT][MAX_LENGTH];
   bit                 loaded       [SLOT_COUNT][MAX_LENGTH];
   logic [SUM_W-1:0]   dist_acc     [SLOT_COUNT];
   logic [COUNT_W-1:0] count_reg;
   logic [LEN_W-1:0]   length_reg;
   logic [SLOT_W-1:0]  expected_best [$];

   int unsigned req_accepted;
   int unsigned results_seen = 0;
   int unsigned csr_writes;
   int unsigned mismatch_count = 0;
   int unsigned idle_cycles = 0;
   int          burst_left;
   int unsigned pattern_tick = 0;
   int unsigned stall_mode = 0;
   logic [SLOT_W-1:0] want_best;

   initial begin
      clock = 1'b0;
   end

   always #1 clock = ~clock;

   task automatic report_mismatch(input string what, input logic [SLOT_W-1:0] want,
                                  input logic [SLOT_W-1:0] got);
      if (mismatch_count < PRINT_LIMIT)
         $display("%0t: %s: expected %0d, got %0d", $realtime, what, want, got);
      mismatch_count++;
   endtask

   function automatic int active_count();
      int c;
      c = count_reg;
      if (c == 0) c = 1;
      if (c > SLOT_COUNT) c = SLOT_COUNT;
      return c;
   endfunction

   function automatic int active_length();
      int n;
      n = length_reg;
      if (n == 0) n = 1;
      if (n > MAX_LENGTH) n = MAX_LENGTH;
      return n;
   endfunction

   // Updates the prediction for one accepted item; a last query component queues a result.
   task automatic apply_item(input kind_type kind, input logic [SLOT_W-1:0] slot,
                             input logic [INDEX_W-1:0] idx, input logic [VALUE_W-1:0] value);
      int n;
      int l;
      int best;
      longint d;
      longint unsigned sq;
      logic [SUM_W:0] total;
      if (kind == KIND_LOAD) begin
         centroid_mem[slot][idx] = value;
         loaded[slot][idx] = 1'b1;
         return;
      end
      n = active_count();
      l = active_length();
      if (idx >= l) return;
      if (idx == 0) begin
         for (int j = 0; j < SLOT_COUNT; j++) dist_acc[j] = '0;
      end
      for (int j = 0; j < n; j++) begin
         d = longint'($signed(value)) - longint'($signed(centroid_mem[j][idx]));
         sq = d * d;
         total = dist_acc[j] + sq;
         dist_acc[j] = total[SUM_W] ? {SUM_W{1'b1}} : total[SUM_W-1:0];
      end
      if (idx != l - 1) return;
      best = 0;
      for (int j = 1; j < n; j++) begin
         if (dist_acc[j] < dist_acc[best]) best = j;
      end
      expected_best.push_back(SLOT_W'(best));
   endtask

   task automatic send_req(input kind_type kind, input int slot, input int idx,
                           input logic [VALUE_W-1:0] value);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            @(negedge clock);
            req_ch.valid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
      burst_left--;
      @(negedge clock);
      req_ch.valid           <= 1'b1;
      req_ch.kind            <= kind;
      req_ch.centroid_slot   <= SLOT_W'(slot);
      req_ch.component_index <= INDEX_W'(idx);
      req_ch.component_value <= value;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      req_accepted++;
      apply_item(kind, SLOT_W'(slot), INDEX_W'(idx), value);
   endtask

   task automatic load_centroid(input int slot, input int idx, input logic [VALUE_W-1:0] value);
      send_req(KIND_LOAD, slot, idx, value);
   endtask

   task automatic query(input int idx, input logic [VALUE_W-1:0] value);
      send_req(KIND_QUERY, $urandom_range(0, SLOT_COUNT - 1), idx, value);
   endtask

   // Closes the request channel and waits until the block has nothing left in flight.
   task automatic settle();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (expected_best.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_register(input csr_index_type which, input logic [CSR_DATA_W-1:0] data);
      settle();
      @(negedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= which;
      csr_ch.data  <= data;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      csr_writes++;
      if (which == CSR_CENTROID_COUNT) count_reg = data[COUNT_W-1:0];
      else length_reg = data;
      @(negedge clock);
      csr_ch.valid <= 1'b0;
   endtask

   function automatic logic [VALUE_W-1:0] pick_value();
      case ($urandom_range(0, 5))
         0: return 16'h8000;
         1: return 16'h7FFF;
         2: return 16'($urandom_range(0, 15)) - 16'd8;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [VALUE_W-1:0] near_value(input int slot, input int idx);
      if ($urandom_range(0, 3) == 0) return pick_value();
      return centroid_mem[slot][idx] + 16'($urandom_range(0, 64)) - 16'd32;
   endfunction

   task automatic test_basic_distance();
      set_register(CSR_CENTROID_COUNT, 3);
      set_register(CSR_VECTOR_LENGTH, 2);
      load_centroid(0, 0, 16'h7FFF);
      load_centroid(0, 1, 16'h8000);
      load_centroid(1, 0, 16'h0000);
      load_centroid(1, 1, 16'h0000);
      load_centroid(2, 0, 16'h8000);
      load_centroid(2, 1, 16'h7FFF);
      query(0, 16'h7FFF);
      query(1, 16'h8000);
      query(0, 16'h0000);
      query(1, 16'h0000);
      query(0, 16'h8000);
      query(1, 16'h7FFF);
      // Slots one and two become equal, so the lower one must win.
      load_centroid(1, 0, 16'h8000);
      load_centroid(1, 1, 16'h7FFF);
      query(0, 16'h8000);
      query(1, 16'h7FFF);
      settle();
   endtask

   task automatic test_broken_queries();
      query(1, 16'h0000);
      query(0, 16'h1234);
      query(0, 16'hFEDC);
      query(1, 16'h0042);
      query(1, 16'h8000);
      query(0, 16'h7FFF);
      query(1, 16'h0001);
      query(2, 16'h0000);
      query(MAX_LENGTH - 1, 16'hFFFF);
      settle();
   endtask

   task automatic test_register_limits();
      set_register(CSR_CENTROID_COUNT, 0);
      set_register(CSR_VECTOR_LENGTH, 0);
      query(0, 16'h5555);
      query(1, 16'hAAAA);
      set_register(CSR_CENTROID_COUNT, 9'h180);
      query(0, 16'h0F0F);
      set_register(CSR_CENTROID_COUNT, 127);
      set_register(CSR_VECTOR_LENGTH, 1);
      for (int j = 0; j < SLOT_COUNT; j++) load_centroid(j, 0, 16'(j * 1024 - 32768));
      query(0, 16'h8000);
      query(0, 16'(63 * 1024 - 32768 + 100));
      query(0, 16'h7FFF);
      query(0, 16'(21 * 1024 - 32768 + 511));
      set_register(CSR_CENTROID_COUNT, 1);
      set_register(CSR_VECTOR_LENGTH, 511);
      for (int i = 1; i < MAX_LENGTH; i++) load_centroid(0, i, pick_value());
      for (int i = 0; i < MAX_LENGTH; i++) query(i, pick_value());
      query(MAX_LENGTH - 1, pick_value());
      settle();
   endtask

   task automatic test_count_change_mid_query();
      set_register(CSR_CENTROID_COUNT, 2);
      set_register(CSR_VECTOR_LENGTH, 3);
      for (int s = 0; s < 4; s++) begin
         for (int i = 0; i < 3; i++) load_centroid(s, i, pick_value());
      end
      query(0, near_value(1, 0));
      set_register(CSR_CENTROID_COUNT, 4);
      query(1, near_value(3, 1));
      query(2, near_value(3, 2));
      query(0, near_value(2, 0));
      query(1, near_value(2, 1));
      set_register(CSR_CENTROID_COUNT, 1);
      query(2, near_value(2, 2));
      settle();
   endtask

   task automatic test_random_traffic();
      int unsigned issued;
      int sel;
      int n;
      int l;
      int nq;
      int shape;
      int target;
      int cnt;
      logic [CSR_DATA_W-1:0] count_data;
      logic [CSR_DATA_W-1:0] length_data;
      issued = 0;
      while (issued < RANDOM_ITEMS) begin
         sel = $urandom_range(0, 9);
         case (sel)
            0: begin
               n = $urandom_range(33, SLOT_COUNT);
               l = $urandom_range(1, 4);
            end
            1: begin
               n = $urandom_range(1, 2);
               l = $urandom_range(129, MAX_LENGTH);
            end
            2: begin
               if ($urandom_range(0, 1) == 0) begin
                  n = 127;
                  l = $urandom_range(0, 1);
               end else begin
                  n = 0;
                  case ($urandom_range(0, 2))
                     0: l = 0;
                     1: l = 511;
                     default: l = MAX_LENGTH;
                  endcase
               end
            end
            default: begin
               n = $urandom_range(1, 8);
               l = $urandom_range(1, 12);
            end
         endcase
         count_data  = {2'($urandom_range(0, 3)), 7'(n)};
         length_data = 9'(l);
         if ($urandom_range(0, 1) == 0) begin
            set_register(CSR_CENTROID_COUNT, count_data);
            set_register(CSR_VECTOR_LENGTH, length_data);
         end else begin
            set_register(CSR_VECTOR_LENGTH, length_data);
            set_register(CSR_CENTROID_COUNT, count_data);
         end
         n = active_count();
         l = active_length();
         for (int s = 0; s < n; s++) begin
            for (int i = 0; i < l; i++) begin
               if (!loaded[s][i]) begin
                  load_centroid(s, i, pick_value());
                  issued++;
               end
            end
         end
         cnt = $urandom_range(0, 3);
         repeat (cnt) begin
            load_centroid($urandom_range(0, SLOT_COUNT - 1), $urandom_range(0, MAX_LENGTH - 1),
                          pick_value());
            issued++;
         end
         nq = (l > 64) ? $urandom_range(1, 2) : $urandom_range(2, 10);
         repeat (nq) begin
            shape = $urandom_range(0, 9);
            target = $urandom_range(0, n - 1);
            if (shape <= 6) begin
               for (int i = 0; i < l; i++) query(i, near_value(target, i));
               issued += l;
            end else if (shape == 7) begin
               cnt = $urandom_range(1, l + 2);
               repeat (cnt) query($urandom_range(0, l - 1), pick_value());
               issued += cnt;
            end else if (shape == 8) begin
               if (l < MAX_LENGTH) begin
                  repeat ($urandom_range(1, 3))
                     query($urandom_range(l, MAX_LENGTH - 1), pick_value());
               end
            end else begin
               for (int i = 0; i < l; i++) begin
                  if ($urandom_range(0, 3) == 0) begin
                     load_centroid($urandom_range(0, n - 1), $urandom_range(0, l - 1),
                                   pick_value());
                     issued++;
                  end
                  query(i, near_value(target, i));
                  issued++;
               end
            end
         end
      end
      settle();
   endtask

   // Response ready follows a pattern that changes its character every so often.
   always @(negedge clock) begin
      pattern_tick++;
      if (pattern_tick % 97 == 0) stall_mode = $urandom_range(0, 3);
      case (stall_mode)
         0: rsp_ch.ready <= 1'b1;
         1: rsp_ch.ready <= ($urandom_range(0, 1) == 0);
         2: rsp_ch.ready <= ($urandom_range(0, 7) == 0);
         default: rsp_ch.ready <= (pattern_tick % 5 != 0);
      endcase
   end

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         results_seen++;
         if (expected_best.size() == 0) begin
            report_mismatch("result without a pending query", '0, rsp_ch.best_centroid);
         end else begin
            want_best = expected_best.pop_front();
            if (rsp_ch.best_centroid !== want_best)
               report_mismatch("best_centroid", want_best, rsp_ch.best_centroid);
         end
      end
   end

   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (csr_ch.valid && csr_ch.ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Watchdog expired with %0d results outstanding.", expected_best.size());
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   initial begin
      reset                  = 1'b1;
      req_ch.valid           = 1'b0;
      req_ch.kind            = KIND_LOAD;
      req_ch.centroid_slot   = '0;
      req_ch.component_index = '0;
      req_ch.component_value = '0;
      csr_ch.valid           = 1'b0;
      csr_ch.index           = CSR_CENTROID_COUNT;
      csr_ch.data            = '0;
      count_reg              = COUNT_RESET;
      length_reg             = LEN_RESET;
      req_accepted           = 0;
      csr_writes             = 0;
      burst_left             = 0;
      for (int j = 0; j < SLOT_COUNT; j++) begin
         dist_acc[j] = '0;
         for (int i = 0; i < MAX_LENGTH; i++) begin
            centroid_mem[j][i] = '0;
            loaded[j][i] = 1'b0;
         end
      end
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_basic_distance();
      test_broken_queries();
      test_register_limits();
      test_count_change_mid_query();
      test_random_traffic();

      $display("Covered %0d request transactions, %0d results and %0d register writes,",
               req_accepted, results_seen, csr_writes);
      $display("including clamped sizes, broken queries and count changes; %0d mismatches.",
               mismatch_count);
      if (mismatch_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
sv/nca_pkg.sv
sv/nca_if.sv
sv/nca_cell.sv
sv/nearest_centroid_assign.sv
dv/testbench.sv
